@@ src/wsd_pkg.sv @@
// Shared types and constants of the WebSocket frame deframer.
// No dependencies; every other file of the block refers to it by scoped names.
package wsd_pkg;

   // Result event codes
   localparam logic [2:0] EvByte  = 3'd0;
   localparam logic [2:0] EvEmpty = 3'd1;
   localparam logic [2:0] EvProto = 3'd2;
   localparam logic [2:0] EvLarge = 3'd3;
   localparam logic [2:0] EvLost  = 3'd4;

   // Opcode of a close frame
   localparam logic [3:0] OpClose = 4'h8;

   // Short length codes that select an extended length
   localparam logic [6:0] Len16Code = 7'd126;
   localparam logic [6:0] Len64Code = 7'd127;

   // Defaults
   localparam int          LengthBitsDef = 64;
   localparam logic [31:0] MaxFrameReset = 32'd65536;

   // Depth of the command queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // Close status capture from the first two payload bytes
   typedef enum logic [1:0] {
      CAP_NONE = 2'd0,
      CAP_HI   = 2'd1,
      CAP_LO   = 2'd2
   } cap_type;

   // One classified item, passed from the parser to the result stage
   typedef struct packed {
      logic [2:0] ev;
      logic [7:0] data;
      logic [7:0] key;
      logic [3:0] opcode;
      logic       fin;
      logic       fe;
      cap_type    cap;
   } cmd_type;

endpackage

@@ src/websocket_frame_deframer_top.sv @@
// Channel | ports                                     | transfer when
// req     | req_push, req_full, req_kind, req_rx_byte | req_push & !req_full
// rsp     | rsp_pop, rsp_empty, rsp_* result fields   | rsp_pop & !rsp_empty
// csr     | csr_valid, csr_ready, csr_data            | csr_valid & csr_ready
//
// One received byte is taken per cycle while req_full is low; its result, if
// any, is written into a four-entry command queue and loaded from there into the
// result register. The queue fills while the result register is held, so a stalled
// consumer raises req_full only once the queue and register are both held.
// Reset is synchronous and active high; csr_ready is always high.
// Top level of the deframer; uses wsd_pkg, wsd_front, wsd_queue and wsd_back.
module websocket_frame_deframer_top #(
   parameter int LENGTH_BITS = wsd_pkg::LengthBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_payload_byte,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_final_fragment,
   output logic        rsp_frame_end,
   output logic [15:0] rsp_close_code,
   output logic        rsp_close_code_valid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   wsd_pkg::cmd_type f_cmd, q_cmd;
   logic             f_push, q_full, q_empty, q_pop, accept;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   wsd_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .kind     (req_kind),
      .rx_byte  (req_rx_byte),
      .cfg_we   (csr_valid && csr_ready),
      .cfg_data (csr_data),
      .cmd_push (f_push),
      .cmd      (f_cmd)
   );

   wsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .push_cmd (f_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_cmd),
      .empty    (q_empty)
   );

   wsd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_cmd                (q_cmd),
      .q_pop                (q_pop),
      .rsp_pop              (rsp_pop),
      .rsp_empty            (rsp_empty),
      .rsp_event_res        (rsp_event_res),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_frame_opcode     (rsp_frame_opcode),
      .rsp_final_fragment   (rsp_final_fragment),
      .rsp_frame_end        (rsp_frame_end),
      .rsp_close_code       (rsp_close_code),
      .rsp_close_code_valid (rsp_close_code_valid)
   );

   // The parser never emits a command into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      f_push |-> !q_full)
      else $error("command pushed into full queue");

   // Frame end only marks payload bytes and empty frames
   a_fe_event: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |->
         (rsp_event_res == wsd_pkg::EvByte || rsp_event_res == wsd_pkg::EvEmpty))
      else $error("frame end on wrong event");

   // Once captured, the close status stays valid on later results
   a_close_sticky: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_close_code_valid) |=> (rsp_empty || rsp_close_code_valid))
      else $error("close status lost");

   // A result appears only after a command was taken from the queue
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(q_pop))
      else $error("result without command");

endmodule

@@ src/wsd_front.sv @@
// Header parser: accepts received bytes, walks the frame header and turns
// payload bytes and frame events into result-stage commands. Uses wsd_pkg.
module wsd_front #(
   parameter int LENGTH_BITS = wsd_pkg::LengthBitsDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             kind,
   input  logic [7:0]       rx_byte,
   input  logic             cfg_we,
   input  logic [31:0]      cfg_data,
   output logic             cmd_push,
   output wsd_pkg::cmd_type cmd
);

   localparam int CmpW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

   typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA, PH_CLOSED
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [3:0]             op_ff, op_in;
   logic                   fin_ff, fin_in;
   logic                   masked_ff, masked_in;
   logic [2:0]             ext_ff, ext_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             keyn_ff, keyn_in;
   logic [1:0]             ofs_ff, ofs_in;
   logic [1:0]             pos_ff, pos_in;
   logic [31:0]            max_ff;

   logic                   hd_go;
   logic [LENGTH_BITS-1:0] hd_len;
   logic [LENGTH_BITS-1:0] len_shift;
   logic [3:0]             b_op;
   logic                   hdr_err;
   logic [7:0]             key_byte;
   logic                   too_large;

   // Extended length shifts in modulo the length width
   assign len_shift = {len_ff[LENGTH_BITS-9:0], rx_byte};

   // First header byte checks: RSV, reserved opcodes, fragmented control
   assign b_op    = rx_byte[3:0];
   assign hdr_err = (rx_byte[6:4] != 3'd0)
                 || (b_op >= 4'd3 && b_op <= 4'd7)
                 || (b_op > 4'd10)
                 || (b_op >= wsd_pkg::OpClose && !rx_byte[7]);

   // Key byte for this payload offset, first key byte at the top
   always_comb begin
      case (ofs_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign too_large = CmpW'(hd_len) > CmpW'(max_ff);

   // Next state and command
   always_comb begin
      phase_in  = phase_ff;
      op_in     = op_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      ext_in    = ext_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      keyn_in   = keyn_ff;
      ofs_in    = ofs_ff;
      pos_in    = pos_ff;
      hd_go     = 1'b0;
      hd_len    = len_ff;
      cmd_push  = 1'b0;
      cmd.ev     = wsd_pkg::EvLost;
      cmd.data   = 8'd0;
      cmd.key    = 8'd0;
      cmd.opcode = op_ff;
      cmd.fin    = fin_ff;
      cmd.fe     = 1'b0;
      cmd.cap    = wsd_pkg::CAP_NONE;

      if (accept && phase_ff != PH_CLOSED) begin
         if (kind) begin
            phase_in = PH_CLOSED;
            cmd_push = 1'b1;
         end else begin
            case (phase_ff)
               PH_HDR0: begin
                  fin_in = rx_byte[7];
                  op_in  = b_op;
                  if (hdr_err) begin
                     phase_in   = PH_CLOSED;
                     cmd_push   = 1'b1;
                     cmd.ev     = wsd_pkg::EvProto;
                     cmd.opcode = b_op;
                     cmd.fin    = rx_byte[7];
                  end else begin
                     phase_in = PH_HDR1;
                  end
               end
               PH_HDR1: begin
                  masked_in = rx_byte[7];
                  key_in    = 32'd0;
                  keyn_in   = 2'd3;
                  len_in    = '0;
                  if (rx_byte[6:0] == wsd_pkg::Len16Code) begin
                     ext_in   = 3'd1;
                     phase_in = PH_EXT;
                  end else if (rx_byte[6:0] == wsd_pkg::Len64Code) begin
                     ext_in   = 3'd7;
                     phase_in = PH_EXT;
                  end else begin
                     ext_in = 3'd0;
                     len_in = {{(LENGTH_BITS-7){1'b0}}, rx_byte[6:0]};
                     if (rx_byte[7]) begin
                        phase_in = PH_KEY;
                     end else begin
                        hd_go  = 1'b1;
                        hd_len = {{(LENGTH_BITS-7){1'b0}}, rx_byte[6:0]};
                     end
                  end
               end
               PH_EXT: begin
                  len_in = len_shift;
                  if (ext_ff != 3'd0) begin
                     ext_in = ext_ff - 3'd1;
                  end else if (masked_ff) begin
                     phase_in = PH_KEY;
                  end else begin
                     hd_go  = 1'b1;
                     hd_len = len_shift;
                  end
               end
               PH_KEY: begin
                  key_in = {key_ff[23:0], rx_byte};
                  if (keyn_ff != 2'd0) begin
                     keyn_in = keyn_ff - 2'd1;
                  end else begin
                     hd_go  = 1'b1;
                     hd_len = len_ff;
                  end
               end
               PH_DATA: begin
                  cmd_push = 1'b1;
                  cmd.ev   = wsd_pkg::EvByte;
                  cmd.data = rx_byte;
                  cmd.key  = key_byte;
                  cmd.fe   = (len_ff == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
                  if (op_ff == wsd_pkg::OpClose && pos_ff == 2'd0) begin
                     cmd.cap = wsd_pkg::CAP_HI;
                  end else if (op_ff == wsd_pkg::OpClose && pos_ff == 2'd1) begin
                     cmd.cap = wsd_pkg::CAP_LO;
                  end
                  if (pos_ff != 2'd2) begin
                     pos_in = pos_ff + 2'd1;
                  end
                  ofs_in = ofs_ff + 2'd1;
                  len_in = len_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                  if (cmd.fe) begin
                     phase_in = (op_ff == wsd_pkg::OpClose) ? PH_CLOSED : PH_HDR0;
                  end
               end
               default: begin
                  phase_in = PH_CLOSED;
               end
            endcase
         end
      end

      // Header complete: check the length, then start payload or finish
      if (hd_go) begin
         ofs_in = 2'd0;
         pos_in = 2'd0;
         len_in = hd_len;
         if (too_large) begin
            phase_in = PH_CLOSED;
            cmd_push = 1'b1;
            cmd.ev   = wsd_pkg::EvLarge;
         end else if (hd_len == '0) begin
            phase_in = (op_ff == wsd_pkg::OpClose) ? PH_CLOSED : PH_HDR0;
            cmd_push = 1'b1;
            cmd.ev   = wsd_pkg::EvEmpty;
            cmd.fe   = 1'b1;
         end else begin
            phase_in = PH_DATA;
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         op_ff     <= 4'd0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         ext_ff    <= 3'd0;
         len_ff    <= '0;
         key_ff    <= 32'd0;
         keyn_ff   <= 2'd0;
         ofs_ff    <= 2'd0;
         pos_ff    <= 2'd0;
         max_ff    <= wsd_pkg::MaxFrameReset;
      end else begin
         phase_ff  <= phase_in;
         op_ff     <= op_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         ext_ff    <= ext_in;
         len_ff    <= len_in;
         key_ff    <= key_in;
         keyn_ff   <= keyn_in;
         ofs_ff    <= ofs_in;
         pos_ff    <= pos_in;
         if (cfg_we) begin
            max_ff <= cfg_data;
         end
      end
   end

endmodule

@@ src/wsd_queue.sv @@
// Short command queue that parts the parser from the result stage.
// Uses wsd_pkg for the command type and depth.
module wsd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wsd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output wsd_pkg::cmd_type pop_cmd,
   output logic             empty
);

   localparam int PtrW = wsd_pkg::QueuePtrW;
   localparam int CntW = wsd_pkg::QueuePtrW + 1;

   wsd_pkg::cmd_type                 store_ff [wsd_pkg::QueueDepth];
   logic [wsd_pkg::QueuePtrW-1:0]    wr_ff, wr_in;
   logic [wsd_pkg::QueuePtrW-1:0]    rd_ff, rd_in;
   logic [CntW-1:0]                  cnt_ff, cnt_in;
   logic                             do_push, do_pop;

   assign full    = (cnt_ff == CntW'(wsd_pkg::QueueDepth));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = store_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = do_push ? wr_ff + PtrW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PtrW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/wsd_back.sv @@
// Result stage: unmasks payload bytes, keeps the close status and holds
// the result register seen on the result ports. Uses wsd_pkg.
module wsd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  wsd_pkg::cmd_type q_cmd,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [2:0]       rsp_event_res,
   output logic [7:0]       rsp_payload_byte,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_final_fragment,
   output logic             rsp_frame_end,
   output logic [15:0]      rsp_close_code,
   output logic             rsp_close_code_valid
);

   logic        vld_ff;
   logic [15:0] cs_ff, cs_in;
   logic        csv_ff, csv_in;
   logic [7:0]  pb;
   logic [2:0]  ev_ff;
   logic [7:0]  pb_ff;
   logic [3:0]  op_ff;
   logic        fin_ff, fe_ff;
   logic [15:0] oc_ff;
   logic        ocv_ff;

   // Take a command when the result register is free or being drained
   assign q_pop = !q_empty && (!vld_ff || rsp_pop);
   assign pb    = q_cmd.data ^ q_cmd.key;

   // Capture the close status from the first two payload bytes
   always_comb begin
      cs_in  = cs_ff;
      csv_in = csv_ff;
      case (q_cmd.cap)
         wsd_pkg::CAP_HI: cs_in = {pb, 8'h00};
         wsd_pkg::CAP_LO: begin
            cs_in  = {cs_ff[15:8], pb};
            csv_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         cs_ff  <= 16'd0;
         csv_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            vld_ff <= 1'b1;
            cs_ff  <= cs_in;
            csv_ff <= csv_in;
         end else if (rsp_pop) begin
            vld_ff <= 1'b0;
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ev_ff  <= q_cmd.ev;
         pb_ff  <= pb;
         op_ff  <= q_cmd.opcode;
         fin_ff <= q_cmd.fin;
         fe_ff  <= q_cmd.fe;
         oc_ff  <= cs_in;
         ocv_ff <= csv_in;
      end
   end

   assign rsp_empty            = !vld_ff;
   assign rsp_event_res        = ev_ff;
   assign rsp_payload_byte     = pb_ff;
   assign rsp_frame_opcode     = op_ff;
   assign rsp_final_fragment   = fin_ff;
   assign rsp_frame_end        = fe_ff;
   assign rsp_close_code       = oc_ff;
   assign rsp_close_code_valid = ocv_ff;

endmodule

@@ bench/websocket_frame_deframer_top_tb.sv @@
// Self-checking testbench for the WebSocket frame deframer top level.
// Holds its own frame parser as a scoreboard; needs websocket_frame_deframer_top and wsd_pkg.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;

   // Opcodes besides close, which comes from the package
   localparam logic [3:0] OpCont   = 4'h0;
   localparam logic [3:0] OpText   = 4'h1;
   localparam logic [3:0] OpBinary = 4'h2;
   localparam logic [3:0] OpPing   = 4'h9;
   localparam logic [3:0] OpPong   = 4'hA;

   localparam int SettleCycles = 8;
   localparam int QuietLimit   = 2000;
   localparam int PhaseItems   = 400;

   typedef enum {RX_HDR0, RX_HDR1, RX_EXT, RX_KEY, RX_DATA, RX_CLOSED} rx_phase_type;
   typedef enum {FORM_SHORT, FORM_16, FORM_64} len_form_type;
   typedef enum {
      CLOSE_RSV, CLOSE_OPCODE, CLOSE_CTRL_FRAG, CLOSE_TOO_LARGE,
      CLOSE_LOST_MID, CLOSE_LOST_IDLE, CLOSE_STATUS, CLOSE_SHORT
   } closing_type;

   typedef struct packed {
      logic [2:0]  ev;
      logic [7:0]  data;
      logic [3:0]  opcode;
      logic        fin;
      logic        fe;
      logic [15:0] code;
      logic        code_ok;
   } deframe_result_type;

   // Frame parser mirror and queue of expected result events
   class deframe_scoreboard_type;
      bit [31:0]          frame_limit = wsd_pkg::MaxFrameReset;
      rx_phase_type       phase = RX_HDR0;
      bit [3:0]           opcode;
      bit                 fin;
      bit                 masked;
      int                 ext_left;
      int                 key_left;
      bit [63:0]          frame_len;
      bit [63:0]          rcvd;
      bit [31:0]          key;
      bit [15:0]          close_status;
      bit                 close_seen;
      deframe_result_type expected_events[$];
      int                 mismatches;

      function void set_limit(bit [31:0] value);
         frame_limit = value;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function void expect_event(bit [2:0] ev, bit [7:0] data, bit fe);
         expected_events.push_back(deframe_result_type'{ev, data, opcode, fin, fe,
                                                        close_status, close_seen});
      endfunction

      // Header complete: check the length, then start payload or finish empty frame
      function void header_done();
         rcvd = 0;
         if (frame_len > 64'(frame_limit)) begin
            phase = RX_CLOSED;
            expect_event(wsd_pkg::EvLarge, 8'h00, 1'b0);
         end else if (frame_len == 0) begin
            phase = (opcode == wsd_pkg::OpClose) ? RX_CLOSED : RX_HDR0;
            expect_event(wsd_pkg::EvEmpty, 8'h00, 1'b1);
         end else begin
            phase = RX_DATA;
         end
      endfunction

      function void note_input(bit kind, bit [7:0] b);
         bit [6:0] len7;
         bit [7:0] kb;
         bit [7:0] pb;
         bit       fe;
         if (phase == RX_CLOSED) return;
         if (kind) begin
            phase = RX_CLOSED;
            expect_event(wsd_pkg::EvLost, 8'h00, 1'b0);
            return;
         end
         case (phase)
            RX_HDR0: begin
               fin    = b[7];
               opcode = b[3:0];
               if (b[6:4] != 3'b000 || (opcode > OpBinary && opcode < wsd_pkg::OpClose) ||
                   opcode > OpPong || (opcode >= wsd_pkg::OpClose && !fin)) begin
                  phase = RX_CLOSED;
                  expect_event(wsd_pkg::EvProto, 8'h00, 1'b0);
               end else begin
                  phase = RX_HDR1;
               end
            end
            RX_HDR1: begin
               masked    = b[7];
               len7      = b[6:0];
               key       = 0;
               key_left  = masked ? 4 : 0;
               frame_len = 0;
               if (len7 == wsd_pkg::Len16Code) begin
                  ext_left = 2;
                  phase    = RX_EXT;
               end else if (len7 == wsd_pkg::Len64Code) begin
                  ext_left = 8;
                  phase    = RX_EXT;
               end else begin
                  ext_left  = 0;
                  frame_len = 64'(len7);
                  if (masked) phase = RX_KEY;
                  else header_done();
               end
            end
            RX_EXT: begin
               frame_len = {frame_len[55:0], b};
               ext_left--;
               if (ext_left == 0) begin
                  if (masked) phase = RX_KEY;
                  else header_done();
               end
            end
            RX_KEY: begin
               key = {key[23:0], b};
               key_left--;
               if (key_left == 0) header_done();
            end
            RX_DATA: begin
               kb = key[(3 - rcvd[1:0]) * 8 +: 8];
               pb = masked ? (b ^ kb) : b;
               // Capture the close status from the first two payload bytes
               if (opcode == wsd_pkg::OpClose) begin
                  if (rcvd == 0) begin
                     close_status = {pb, 8'h00};
                  end else if (rcvd == 1) begin
                     close_status[7:0] = pb;
                     close_seen = 1'b1;
                  end
               end
               rcvd++;
               fe = (rcvd == frame_len);
               if (fe) phase = (opcode == wsd_pkg::OpClose) ? RX_CLOSED : RX_HDR0;
               expect_event(wsd_pkg::EvByte, pb, fe);
            end
            default: phase = RX_CLOSED;
         endcase
      endfunction

      function void compare_field(string name, bit [63:0] want, bit [63:0] got);
         if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_event(deframe_result_type got);
         deframe_result_type want;
         if (expected_events.size() == 0) begin
            $error("unexpected result: event %0d, byte %0h", got.ev, got.data);
            mismatches++;
            return;
         end
         want = expected_events.pop_front();
         compare_field("event_res", want.ev, got.ev);
         compare_field("payload_byte", want.data, got.data);
         compare_field("frame_opcode", want.opcode, got.opcode);
         compare_field("final_fragment", want.fin, got.fin);
         compare_field("frame_end", want.fe, got.fe);
         compare_field("close_code", want.code, got.code);
         compare_field("close_code_valid", want.code_ok, got.code_ok);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_kind = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_payload_byte;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_final_fragment;
   logic        rsp_frame_end;
   logic [15:0] rsp_close_code;
   logic        rsp_close_code_valid;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = 32'h0;

   deframe_scoreboard_type sb = new;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_taken = 0;
   int results_seen = 0;
   int frames_sent = 0;
   int limits_written = 0;
   int quiet_cycles = 0;
   bit [31:0]   cur_limit;
   closing_type closing;

   websocket_frame_deframer_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_kind            (req_kind),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_event_res       (rsp_event_res),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_frame_opcode    (rsp_frame_opcode),
      .rsp_final_fragment  (rsp_final_fragment),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_close_code      (rsp_close_code),
      .rsp_close_code_valid(rsp_close_code_valid),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always #10 clock = ~clock;

   // Note every input transfer in the scoreboard
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         sb.note_input(req_kind, req_rx_byte);
         items_taken++;
      end
   end

   // Check each result transfer, then decide whether to stall the next one
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         sb.check_event(deframe_result_type'{rsp_event_res, rsp_payload_byte,
                                             rsp_frame_opcode, rsp_final_fragment,
                                             rsp_frame_end, rsp_close_code,
                                             rsp_close_code_valid});
         results_seen++;
      end
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Abort when neither side has moved for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                  quiet_cycles, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one item, idling first at random, and hold it until transferred
   task automatic push_item(bit kind, bit [7:0] data);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_push    <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= data;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Stop sending until every expected result has come, then let the pipe settle
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_limit(bit [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_limit(value);
      cur_limit = value;
      limits_written++;
      csr_valid <= 1'b0;
   endtask

   task automatic send_header(bit fin, bit [3:0] op, bit masked, bit [63:0] len,
                              len_form_type form, bit [31:0] key);
      push_item(1'b0, {fin, 3'b000, op});
      case (form)
         FORM_SHORT: push_item(1'b0, {masked, len[6:0]});
         FORM_16: begin
            push_item(1'b0, {masked, wsd_pkg::Len16Code});
            push_item(1'b0, len[15:8]);
            push_item(1'b0, len[7:0]);
         end
         default: begin
            push_item(1'b0, {masked, wsd_pkg::Len64Code});
            for (int i = 7; i >= 0; i--) push_item(1'b0, len[i * 8 +: 8]);
         end
      endcase
      if (masked)
         for (int i = 3; i >= 0; i--) push_item(1'b0, key[i * 8 +: 8]);
   endtask

   // Whole frame; the fill pattern alternates all-zero and all-one bytes
   task automatic send_frame(bit fin, bit [3:0] op, bit masked, int len, len_form_type form,
                             bit fill);
      bit [31:0] key;
      key = fill ? 32'hFF00_00FF : $urandom;
      send_header(fin, op, masked, 64'(len), form, key);
      for (int i = 0; i < len; i++)
         push_item(1'b0, fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
      frames_sent++;
   endtask

   // Legal frame of random kind and size, kept within the current limit
   task automatic send_random_frame();
      int           pick;
      int           len;
      bit [3:0]     op;
      bit           fin;
      len_form_type form;
      pick = $urandom_range(0, 9);
      fin  = ($urandom_range(0, 7) != 0);
      case (pick)
         0, 1, 2, 3: op = OpText;
         4, 5:       op = OpBinary;
         6:          op = OpCont;
         7:          op = OpPing;
         8:          op = OpPong;
         default: begin
            op  = $urandom_range(0, 1) ? OpCont : OpText;
            fin = 1'b0;
         end
      endcase
      if (op >= wsd_pkg::OpClose) fin = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 10)      len = 0;
      else if (pick < 75) len = $urandom_range(1, 12);
      else if (pick < 90) len = $urandom_range(13, 125);
      else                len = $urandom_range(126, 300);
      if (64'(len) > 64'(cur_limit)) len = int'(cur_limit);
      pick = $urandom_range(0, 7);
      if (len >= 126) form = (pick < 2) ? FORM_64 : FORM_16;
      else if (pick == 0) form = FORM_16;
      else if (pick == 1) form = FORM_64;
      else form = FORM_SHORT;
      send_frame(fin, op, 1'($urandom_range(0, 1)), len, form, 1'b0);
   endtask

   task automatic run_phase(int send_pct, int recv_pct, bit [31:0] limit);
      int start;
      drain();
      write_limit(limit);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = items_taken;
      while (items_taken - start < PhaseItems) begin
         if ($urandom_range(0, 24) == 0) drain();
         send_random_frame();
      end
   endtask

   initial begin
      int        len;
      bit [63:0] big_len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero limit with empty frames, then widest limit with patterned payload
      write_limit(32'h0);
      send_frame(1'b1, OpText, 1'b0, 0, FORM_SHORT, 1'b1);
      send_frame(1'b1, OpPing, 1'b1, 0, FORM_16, 1'b1);
      drain();
      write_limit(32'hFFFF_FFFF);
      send_frame(1'b0, OpBinary, 1'b0, 3, FORM_16, 1'b1);
      send_frame(1'b1, OpCont, 1'b1, 2, FORM_SHORT, 1'b1);

      // Random frames under three idling patterns and limits
      run_phase(25, 46, $urandom_range(130, 400));
      run_phase(46, 25, 32'hFFFF_FFFF);
      run_phase(0, 0, $urandom_range(1, 12));

      // Close the block by one of the ways it can shut down
      closing = closing_type'($urandom_range(0, 7));
      case (closing)
         CLOSE_RSV: push_item(1'b0, {1'b1, 3'($urandom_range(1, 7)), OpText});
         CLOSE_OPCODE:
            push_item(1'b0, {1'($urandom_range(0, 1)), 3'b000,
                             $urandom_range(0, 1) ? 4'($urandom_range(3, 7))
                                                  : 4'($urandom_range(11, 15))});
         CLOSE_CTRL_FRAG: push_item(1'b0, {1'b0, 3'b000, 4'($urandom_range(8, 10))});
         CLOSE_TOO_LARGE: begin
            big_len = 64'(cur_limit) + 64'd1 + (64'($urandom_range(0, 255)) << 40);
            big_len[63] = 1'($urandom_range(0, 1));
            send_header(1'b1, OpBinary, 1'($urandom_range(0, 1)), big_len, FORM_64, $urandom);
         end
         CLOSE_LOST_MID: begin
            len = int'(cur_limit);
            send_header(1'b1, OpText, 1'($urandom_range(0, 1)), 64'(len), FORM_SHORT,
                        $urandom);
            repeat ($urandom_range(0, len - 1)) push_item(1'b0, 8'($urandom_range(0, 255)));
            push_item(1'b1, 8'($urandom_range(0, 255)));
         end
         CLOSE_LOST_IDLE: push_item(1'b1, 8'($urandom_range(0, 255)));
         CLOSE_STATUS: begin
            len = $urandom_range(2, 6);
            if (len > int'(cur_limit)) len = int'(cur_limit);
            send_frame(1'b1, wsd_pkg::OpClose, 1'($urandom_range(0, 1)), len, FORM_SHORT,
                       1'b0);
         end
         default: send_frame(1'b1, wsd_pkg::OpClose, 1'($urandom_range(0, 1)),
                             $urandom_range(0, 1), FORM_SHORT, 1'b0);
      endcase

      // Closed block: further bytes and a lost connection must stay silent
      repeat (5) push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      push_item(1'b1, 8'($urandom_range(0, 255)));
      drain();
      repeat (20) @(posedge clock);

      if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
      $display("Covered %0d input transfers in %0d frames and %0d checked results",
               items_taken, frames_sent, results_seen);
      $display("Used %0d length limits; block closed by %s", limits_written, closing.name());
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
src/wsd_pkg.sv
src/wsd_front.sv
src/wsd_queue.sv
src/wsd_back.sv
src/websocket_frame_deframer_top.sv
bench/websocket_frame_deframer_top_tb.sv
